FILE: rtl/core/rrw_pkg.sv
// shared types and constants of the receive reorder window
package rrw_pkg;

  // window size is a power of two so a slot is the low bits of a sequence
  localparam int WIN_LOG2 = 4;
  localparam int WINDOW   = 1 << WIN_LOG2;
  localparam int IDX_W    = WIN_LOG2;
  localparam int CNT_W    = WIN_LOG2 + 1;
  localparam int SEQ_W    = 32;
  localparam int HDL_W    = 16;
  localparam int KIND_W   = 4;
  localparam int OP_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUT     = 2'd0,
    OP_DELIVER = 2'd1,
    OP_PROBE   = 2'd2,
    OP_REPORT  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DELIVERED = 4'd0,
    KIND_STORED    = 4'd1,
    KIND_DUP       = 4'd2,
    KIND_BEYOND    = 4'd3,
    KIND_NOTHING   = 4'd4,
    KIND_DONE      = 4'd5,
    KIND_MISSING   = 4'd6,
    KIND_NONE      = 4'd7,
    KIND_BASE      = 4'd8
  } kind_t;

  typedef struct packed {
    logic             vld;
    kind_t            kind;
    logic [SEQ_W-1:0] seq_low;
    logic [SEQ_W-1:0] seq_high;
    logic [HDL_W-1:0] handle;
    logic             last;
  } res_t;

endpackage

FILE: rtl/core/rrw_ram.sv
// handle store: one write port, one registered read port
module rrw_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/rrw_ctrl.sv
// window sequencer: valid bits, base sequence, delivery walk, probe scan, base advance
module rrw_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rrw_pkg::OP_W-1:0]      in_operation,
  input  logic [rrw_pkg::SEQ_W-1:0]     in_seq,
  input  logic [rrw_pkg::HDL_W-1:0]     in_packet_handle,
  input  logic                          out_free,
  output rrw_pkg::res_t                 res,
  output logic                          ram_we,
  output logic [rrw_pkg::IDX_W-1:0]     ram_waddr,
  output logic [rrw_pkg::HDL_W-1:0]     ram_wdata,
  output logic                          ram_re,
  output logic [rrw_pkg::IDX_W-1:0]     ram_raddr,
  input  logic [rrw_pkg::HDL_W-1:0]     ram_rdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_TAIL,
    ST_SCAN_GAP,
    ST_SCAN_END,
    ST_CLEAR,
    ST_FIN
  } state_t;

  localparam logic [rrw_pkg::CNT_W-1:0] K_WIN = rrw_pkg::CNT_W'(rrw_pkg::WINDOW);
  localparam logic [rrw_pkg::CNT_W-1:0] K_ONE = rrw_pkg::CNT_W'(1);

  state_t                        state_r, state_nxt;
  rrw_pkg::op_t                  op_r, op_nxt;
  logic [rrw_pkg::SEQ_W-1:0]     seq_r, seq_nxt;
  logic [rrw_pkg::HDL_W-1:0]     hdl_r, hdl_nxt;
  logic [rrw_pkg::SEQ_W-1:0]     ne_r, ne_nxt;
  logic [rrw_pkg::WINDOW-1:0]    valid_r, valid_nxt;
  logic [rrw_pkg::CNT_W-1:0]     k_r, k_nxt;
  logic [rrw_pkg::CNT_W-1:0]     gap_r, gap_nxt;
  logic [rrw_pkg::CNT_W-1:0]     adv_r, adv_nxt;
  logic                          rd_pend_r, rd_pend_nxt;
  logic [rrw_pkg::SEQ_W-1:0]     pend_seq_r, pend_seq_nxt;
  rrw_pkg::kind_t                fin_kind_r, fin_kind_nxt;
  logic [rrw_pkg::SEQ_W-1:0]     fin_lo_r, fin_lo_nxt;
  logic [rrw_pkg::SEQ_W-1:0]     fin_hi_r, fin_hi_nxt;

  logic [rrw_pkg::IDX_W-1:0]     head_idx;
  logic [rrw_pkg::IDX_W-1:0]     scan_idx;
  logic [rrw_pkg::SEQ_W-1:0]     in_off;
  logic [rrw_pkg::SEQ_W-1:0]     tail_off;
  logic                          k_full;
  logic                          load_pend;
  logic                          can_issue;
  logic                          emit_fin;

  assign head_idx  = ne_r[rrw_pkg::IDX_W-1:0];
  assign scan_idx  = ne_r[rrw_pkg::IDX_W-1:0] + k_r[rrw_pkg::IDX_W-1:0];
  assign in_off    = in_seq - ne_r;
  assign tail_off  = seq_r - ne_r;
  assign k_full    = (k_r == K_WIN);
  // a read word waiting in the ram output moves on when the output register frees
  assign load_pend = rd_pend_r && out_free;
  assign can_issue = !rd_pend_r || load_pend;
  assign emit_fin  = (state_r == ST_FIN) && !rd_pend_r && out_free;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    seq_nxt      = seq_r;
    hdl_nxt      = hdl_r;
    ne_nxt       = ne_r;
    valid_nxt    = valid_r;
    k_nxt        = k_r;
    gap_nxt      = gap_r;
    adv_nxt      = adv_r;
    pend_seq_nxt = pend_seq_r;
    fin_kind_nxt = fin_kind_r;
    fin_lo_nxt   = fin_lo_r;
    fin_hi_nxt   = fin_hi_r;
    ram_we       = 1'b0;
    ram_waddr    = seq_r[rrw_pkg::IDX_W-1:0];
    ram_wdata    = hdl_r;
    ram_re       = 1'b0;
    ram_raddr    = head_idx;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = rrw_pkg::op_t'(in_operation);
          seq_nxt    = in_seq;
          hdl_nxt    = in_packet_handle;
          k_nxt      = '0;
          fin_hi_nxt = '0;
          case (rrw_pkg::op_t'(in_operation))
            rrw_pkg::OP_PUT: begin
              if (in_seq < ne_r) begin
                fin_kind_nxt = rrw_pkg::KIND_DUP;
                fin_lo_nxt   = in_seq;
                state_nxt    = ST_FIN;
              end else if (in_off[rrw_pkg::SEQ_W-1:rrw_pkg::IDX_W] != '0) begin
                state_nxt = ST_RUN;
              end else begin
                state_nxt = ST_TAIL;
              end
            end
            rrw_pkg::OP_DELIVER: begin
              if (valid_r[head_idx]) begin
                state_nxt = ST_RUN;
              end else begin
                fin_kind_nxt = rrw_pkg::KIND_NOTHING;
                fin_lo_nxt   = ne_r;
                state_nxt    = ST_FIN;
              end
            end
            rrw_pkg::OP_PROBE: begin
              state_nxt = ST_SCAN_GAP;
            end
            rrw_pkg::OP_REPORT: begin
              if (ne_r < in_seq) begin
                adv_nxt   = (in_off >= rrw_pkg::SEQ_W'(rrw_pkg::WINDOW)) ? K_WIN
                                                                        : in_off[rrw_pkg::CNT_W-1:0];
                state_nxt = ST_CLEAR;
              end else begin
                fin_kind_nxt = rrw_pkg::KIND_BASE;
                fin_lo_nxt   = ne_r;
                state_nxt    = ST_FIN;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_RUN: begin
        if (k_full || !valid_r[head_idx]) begin
          if (op_r == rrw_pkg::OP_PUT) begin
            state_nxt = ST_TAIL;
          end else begin
            fin_kind_nxt = rrw_pkg::KIND_DONE;
            fin_lo_nxt   = ne_r;
            state_nxt    = ST_FIN;
          end
        end else if (can_issue) begin
          ram_re              = 1'b1;
          valid_nxt[head_idx] = 1'b0;
          pend_seq_nxt        = ne_r;
          ne_nxt              = ne_r + 32'd1;
          k_nxt               = k_r + K_ONE;
        end
      end

      ST_TAIL: begin
        fin_lo_nxt = seq_r;
        if (tail_off[rrw_pkg::SEQ_W-1:rrw_pkg::IDX_W] != '0) begin
          fin_kind_nxt = rrw_pkg::KIND_BEYOND;
        end else begin
          ram_we = 1'b1;
          valid_nxt[seq_r[rrw_pkg::IDX_W-1:0]] = 1'b1;
          fin_kind_nxt = rrw_pkg::KIND_STORED;
        end
        state_nxt = ST_FIN;
      end

      ST_SCAN_GAP: begin
        if (k_full) begin
          fin_kind_nxt = rrw_pkg::KIND_NONE;
          fin_lo_nxt   = ne_r;
          state_nxt    = ST_FIN;
        end else if (!valid_r[scan_idx]) begin
          gap_nxt   = k_r;
          k_nxt     = k_r + K_ONE;
          state_nxt = ST_SCAN_END;
        end else begin
          k_nxt = k_r + K_ONE;
        end
      end

      ST_SCAN_END: begin
        if (k_full || valid_r[scan_idx]) begin
          fin_kind_nxt = rrw_pkg::KIND_MISSING;
          fin_lo_nxt   = ne_r + rrw_pkg::SEQ_W'(gap_r);
          fin_hi_nxt   = ne_r + rrw_pkg::SEQ_W'(k_r) - 32'd1;
          state_nxt    = ST_FIN;
        end else begin
          k_nxt = k_r + K_ONE;
        end
      end

      ST_CLEAR: begin
        if (k_r == adv_r) begin
          ne_nxt       = seq_r;
          fin_kind_nxt = rrw_pkg::KIND_BASE;
          fin_lo_nxt   = seq_r;
          state_nxt    = ST_FIN;
        end else begin
          valid_nxt[scan_idx] = 1'b0;
          k_nxt = k_r + K_ONE;
        end
      end

      ST_FIN: begin
        if (emit_fin) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (ram_re) begin
      rd_pend_nxt = 1'b1;
    end else if (load_pend) begin
      rd_pend_nxt = 1'b0;
    end else begin
      rd_pend_nxt = rd_pend_r;
    end
  end

  // delivered words take priority; the closing word waits until none is in flight
  always_comb begin
    res = '0;
    if (load_pend) begin
      res.vld     = 1'b1;
      res.kind    = rrw_pkg::KIND_DELIVERED;
      res.seq_low = pend_seq_r;
      res.handle  = ram_rdata;
      res.last    = 1'b0;
    end else if (emit_fin) begin
      res.vld      = 1'b1;
      res.kind     = fin_kind_r;
      res.seq_low  = fin_lo_r;
      res.seq_high = fin_hi_r;
      res.last     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ne_r      <= '0;
      valid_r   <= '0;
      rd_pend_r <= 1'b0;
      k_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      ne_r      <= ne_nxt;
      valid_r   <= valid_nxt;
      rd_pend_r <= rd_pend_nxt;
      k_r       <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    seq_r      <= seq_nxt;
    hdl_r      <= hdl_nxt;
    gap_r      <= gap_nxt;
    adv_r      <= adv_nxt;
    pend_seq_r <= pend_seq_nxt;
    fin_kind_r <= fin_kind_nxt;
    fin_lo_r   <= fin_lo_nxt;
    fin_hi_r   <= fin_hi_nxt;
  end

  ap_issue_adv: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (rd_pend_r && (ne_r == $past(ne_r) + 32'd1)))
    else $error("delivery read did not advance the base");

  ap_no_issue_over: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (!rd_pend_r || load_pend))
    else $error("read issued over an unconsumed word");

  ap_last_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && res.last) |-> (!rd_pend_r && !ram_re))
    else $error("closing word overtook a delivered word");

  ap_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r <= K_WIN) && ((state_r != ST_CLEAR) || ((adv_r != '0) && (adv_r <= K_WIN))))
    else $error("walk counter out of range");

  ap_write_alone: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (!ram_re && (state_r == ST_TAIL)))
    else $error("handle write outside the store step");

endmodule

FILE: rtl/core/reorder_receive_window.sv
// top level of the receive reorder window: sequencer, handle ram, output register
//
//   channel   direction  ports
//   in_       input      in_valid/in_ready, in_operation, in_seq, in_packet_handle
//   out_      output     out_valid/out_ready, out_kind, out_seq_low, out_seq_high,
//                        out_handle, out_last
//
// one word at a time. a duplicate put, an empty deliver or a report at or below the base
// closes without a walk; a put inside the window stores its handle. a delivery, and a put
// past the window end before it is stored or refused, walk the filled slots from the base,
// the single read port of the handle ram reading one slot a cycle while the output is not
// stalled. a probe scans for the first gap and its end; a report clears the slots it skips.
// synchronous reset empties the window and sets the base to zero; no clearing pass.
// a stalled output holds the delivery walk; a new word is taken while the last result waits.
module reorder_receive_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rrw_pkg::OP_W-1:0]  in_operation,
  input  logic [rrw_pkg::SEQ_W-1:0] in_seq,
  input  logic [rrw_pkg::HDL_W-1:0] in_packet_handle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rrw_pkg::KIND_W-1:0] out_kind,
  output logic [rrw_pkg::SEQ_W-1:0] out_seq_low,
  output logic [rrw_pkg::SEQ_W-1:0] out_seq_high,
  output logic [rrw_pkg::HDL_W-1:0] out_handle,
  output logic                      out_last
);

  rrw_pkg::res_t                 res;
  logic                          out_free;
  logic                          ram_we;
  logic [rrw_pkg::IDX_W-1:0]     ram_waddr;
  logic [rrw_pkg::HDL_W-1:0]     ram_wdata;
  logic                          ram_re;
  logic [rrw_pkg::IDX_W-1:0]     ram_raddr;
  logic [rrw_pkg::HDL_W-1:0]     ram_rdata;

  logic                          out_valid_r;
  rrw_pkg::res_t                 out_r;

  assign out_free = !out_valid_r || out_ready;

  rrw_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_seq           (in_seq),
    .in_packet_handle (in_packet_handle),
    .out_free         (out_free),
    .res              (res),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  rrw_ram #(
    .DEPTH (rrw_pkg::WINDOW),
    .WIDTH (rrw_pkg::HDL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.vld) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_r.kind;
  assign out_seq_low  = out_r.seq_low;
  assign out_seq_high = out_r.seq_high;
  assign out_handle   = out_r.handle;
  assign out_last     = out_r.last;

endmodule
